// ----- hw/rtl/jpeg_block_coefficient_decoder_unit_defines.svh -----
// assertion macros for the block coefficient decoder checker
`ifndef JPEG_BLOCK_COEFFICIENT_DECODER_UNIT_DEFINES_SVH
`define JPEG_BLOCK_COEFFICIENT_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define JBCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JBCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/jbcd_pkg.sv -----
// types and constants of the block coefficient decoder
package jbcd_pkg;

  typedef struct packed {
    logic [1:0]  component;
    logic [7:0]  symbol;
    logic [10:0] extra_bits;
  } item_t;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic [5:0]         position;
    logic               last_in_block;
    logic               error;
  } result_t;

  localparam logic [5:0] BlockLast     = 6'd63;
  localparam logic [3:0] DcMaxCategory = 4'd11;
  localparam logic [3:0] AcMaxSize     = 4'd10;
  localparam logic [7:0] SymZrl        = 8'hF0;
  localparam logic [7:0] SymEob        = 8'h00;
  localparam logic [6:0] ZrlSpan       = 7'd15;

endpackage

// ----- hw/rtl/jpeg_block_coefficient_decoder_unit.sv -----
// dc/ac run-length coefficient decoder for baseline jpeg blocks
// path: an item is registered on the take, decoded in S_MAG, for dc summed in S_DC,
// and its beats are loaded in S_EMIT; item_ready stays low from the take until the last
// beat is loaded; one beat a cycle while result_ready does not stall
// the rate is set by the single emit sequencer and the one shared 16-bit adder
// reset: synchronous, clears the block position (next item is dc) and all dc predictors
module jpeg_block_coefficient_decoder_unit #(
  parameter int NUM_COMPONENTS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  jbcd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output jbcd_pkg::result_t result
);

  localparam int CompW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAG  = 2'd1;
  localparam logic [1:0] S_DC   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state;
  jbcd_pkg::item_t   item_q;
  logic [5:0]        pos;
  logic [5:0]        cur;
  logic [5:0]        end_pos;
  logic [15:0]       value;
  logic              has_value;
  logic              err;
  logic [15:0]       pred [NUM_COMPONENTS];
  logic              out_valid;
  jbcd_pkg::result_t out_q;

  logic [3:0]  size;
  logic [3:0]  run;
  logic [3:0]  size_m1;
  logic [11:0] mask;
  logic [11:0] masked;
  logic [11:0] masked_top;
  logic        top;
  logic [15:0] add_a;
  logic [15:0] add_b;
  logic [15:0] add_sum;
  logic [6:0]  sum_run;
  logic [6:0]  sum_zrl;
  logic        is_dc;
  logic        dec_err;
  logic [5:0]  dec_end;
  logic        dec_hv;
  logic [CompW-1:0] comp_idx;
  logic        load;
  logic        done;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = out_valid;
  assign result       = out_q;

  assign size       = item_q.symbol[3:0];
  assign run        = item_q.symbol[7:4];
  assign size_m1    = size - 4'd1;
  assign mask       = (12'd1 << size) - 12'd1;
  assign masked     = {1'b0, item_q.extra_bits} & mask;
  assign masked_top = masked >> size_m1;
  assign top        = masked_top[0];
  assign comp_idx   = item_q.component[CompW-1:0];
  assign is_dc      = (pos == 6'd0);
  assign sum_run    = {1'b0, pos} + {3'b000, run};
  assign sum_zrl    = {1'b0, pos} + jbcd_pkg::ZrlSpan;

  // shared adder: magnitude offset, then predictor update
  always_comb begin
    if (state == S_DC) begin
      add_a = pred[comp_idx];
      add_b = value;
    end else begin
      add_a = {4'd0, masked};
      if (size == 4'd0 || top) begin
        add_b = 16'd0;
      end else begin
        add_b = 16'd1 - (16'd1 << size);
      end
    end
  end
  assign add_sum = add_a + add_b;

  always_comb begin
    dec_err = 1'b0;
    dec_end = pos;
    dec_hv  = 1'b1;
    if (is_dc) begin
      dec_err = (32'(item_q.component) >= 32'(NUM_COMPONENTS)) ||
                (item_q.symbol > {4'd0, jbcd_pkg::DcMaxCategory});
      dec_end = 6'd0;
    end else if (item_q.symbol == jbcd_pkg::SymEob) begin
      dec_end = jbcd_pkg::BlockLast;
      dec_hv  = 1'b0;
    end else if (item_q.symbol == jbcd_pkg::SymZrl) begin
      dec_err = (sum_zrl > {1'b0, jbcd_pkg::BlockLast});
      dec_end = sum_zrl[5:0];
      dec_hv  = 1'b0;
    end else begin
      dec_err = (size == 4'd0) || (size > jbcd_pkg::AcMaxSize) ||
                (sum_run > {1'b0, jbcd_pkg::BlockLast});
      dec_end = sum_run[5:0];
    end
  end

  assign load = (state == S_EMIT) && (!out_valid || result_ready);
  assign done = err || (cur == end_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= 6'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        pred[i] <= 16'd0;
      end
    end else begin
      if (result_ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_q <= item;
            state  <= S_MAG;
          end
        end
        S_MAG: begin
          value     <= add_sum;
          err       <= dec_err;
          end_pos   <= dec_end;
          has_value <= dec_hv;
          cur       <= pos;
          state     <= (is_dc && !dec_err) ? S_DC : S_EMIT;
        end
        S_DC: begin
          value          <= add_sum;
          pred[comp_idx] <= add_sum;
          state          <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            out_valid           <= 1'b1;
            out_q.coefficient   <= (!err && has_value && cur == end_pos) ?
                                   $signed(value) : 16'sd0;
            out_q.position      <= cur;
            out_q.last_in_block <= err || (cur == jbcd_pkg::BlockLast);
            out_q.error         <= err;
            if (done) begin
              pos   <= (err || end_pos == jbcd_pkg::BlockLast) ? 6'd0 : end_pos + 6'd1;
              state <= S_IDLE;
            end else begin
              cur <= cur + 6'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/jbcd_checker.sv -----
// port-level checker for the block coefficient decoder, with its bind
`include "jpeg_block_coefficient_decoder_unit_defines.svh"

module jbcd_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input jbcd_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input jbcd_pkg::result_t result
);

  // stalled result beat holds
  `JBCD_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")

  // one item at a time
  `JBCD_ASSERT_NXT(a_busy_after_take, clk, rst, item_valid && item_ready, !item_ready, "input taken again before item finished")

  // final zigzag index always closes the block
  `JBCD_ASSERT_IMP(a_last_at_end, clk, rst, result_valid && result.position == jbcd_pkg::BlockLast, result.last_in_block, "index 63 without last flag")

  // error beat is a zero that ends the block
  `JBCD_ASSERT_IMP(a_error_beat, clk, rst, result_valid && result.error, result.last_in_block && result.coefficient == 16'sd0, "malformed error beat")

endmodule

bind jpeg_block_coefficient_decoder_unit jbcd_checker u_jbcd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
